/* rtl/core/bmlsu_pkg.sv */
// Shared types and constants of the byte memory load/store unit.
package bmlsu_pkg;

  localparam int DEFAULT_ADDR_BITS = 16;
  localparam int LANES             = 4;
  localparam int LANE_BITS         = 2;
  localparam int BYTE_BITS         = 8;
  localparam int WORD_BITS         = 32;
  localparam int OP_BITS           = 4;
  localparam int TAG_BITS          = 5;

  typedef enum logic [OP_BITS-1:0] {
    OP_FETCH = 4'd0,
    OP_LB    = 4'd1,
    OP_LH    = 4'd2,
    OP_LW    = 4'd3,
    OP_LBU   = 4'd4,
    OP_LHU   = 4'd5,
    OP_SB    = 4'd6,
    OP_SH    = 4'd7,
    OP_SW    = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    W_BYTE = 2'd0,
    W_HALF = 2'd1,
    W_WORD = 2'd2
  } width_t;

  // Request control carried from the address stage to the response stage
  typedef struct packed {
    logic                 load;
    logic                 sext;
    width_t               width;
    logic [LANE_BITS-1:0] lane;
    logic [TAG_BITS-1:0]  tag;
  } rsp_ctrl_t;

endpackage

/* rtl/core/bmlsu_bank.sv */
// One byte lane of the data memory: single-port synchronous RAM, registered read.
module bmlsu_bank #(
  parameter int ROW_BITS = bmlsu_pkg::DEFAULT_ADDR_BITS - bmlsu_pkg::LANE_BITS
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic                           we,
  input  logic [ROW_BITS-1:0]            row,
  input  logic [bmlsu_pkg::BYTE_BITS-1:0] wdata,
  output logic [bmlsu_pkg::BYTE_BITS-1:0] rdata
);
  import bmlsu_pkg::*;

  logic [BYTE_BITS-1:0] mem [2**ROW_BITS];

  // Write the byte on a store, read the row on every request
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[row] <= wdata;
      end
      rdata <= mem[row];
    end
  end

endmodule

/* rtl/core/bmlsu_route.sv */
// Address stage: decode the request and steer row, enable and data to each byte lane.
module bmlsu_route #(
  parameter int ADDR_BITS = bmlsu_pkg::DEFAULT_ADDR_BITS
) (
  input  logic [bmlsu_pkg::OP_BITS-1:0]   op,
  input  logic [ADDR_BITS-1:0]            address,
  input  logic [bmlsu_pkg::WORD_BITS-1:0] store_data,
  input  logic [bmlsu_pkg::TAG_BITS-1:0]  dest_tag,
  output logic [bmlsu_pkg::LANES-1:0][ADDR_BITS-bmlsu_pkg::LANE_BITS-1:0] bank_row,
  output logic [bmlsu_pkg::LANES-1:0]     bank_we,
  output logic [bmlsu_pkg::LANES-1:0][bmlsu_pkg::BYTE_BITS-1:0] bank_wdata,
  output bmlsu_pkg::rsp_ctrl_t            ctrl
);
  import bmlsu_pkg::*;

  localparam int ROW_BITS = ADDR_BITS - LANE_BITS;

  logic                        load;
  logic                        store;
  logic                        sext;
  width_t                      width;
  logic [LANE_BITS:0]          nbytes;
  logic [ROW_BITS-1:0]         base;
  logic [LANE_BITS-1:0]        lane;
  logic [LANES-1:0][LANE_BITS-1:0] kofs;

  // Decode the operation into direction, size and extension
  always_comb begin
    load  = 1'b0;
    store = 1'b0;
    sext  = 1'b0;
    width = W_WORD;
    case (op_t'(op))
      OP_FETCH: load = 1'b1;
      OP_LW:    load = 1'b1;
      OP_LB:    begin load = 1'b1; sext = 1'b1; width = W_BYTE; end
      OP_LH:    begin load = 1'b1; sext = 1'b1; width = W_HALF; end
      OP_LBU:   begin load = 1'b1; width = W_BYTE; end
      OP_LHU:   begin load = 1'b1; width = W_HALF; end
      OP_SB:    begin store = 1'b1; width = W_BYTE; end
      OP_SH:    begin store = 1'b1; width = W_HALF; end
      OP_SW:    store = 1'b1;
      default:  begin load = 1'b0; store = 1'b0; end
    endcase
  end

  // Bytes touched by the access
  always_comb begin
    case (width)
      W_BYTE:  nbytes = (LANE_BITS+1)'(1);
      W_HALF:  nbytes = (LANE_BITS+1)'(2);
      W_WORD:  nbytes = (LANE_BITS+1)'(LANES);
      default: nbytes = (LANE_BITS+1)'(LANES);
    endcase
  end

  assign base = address[ADDR_BITS-1:LANE_BITS];
  assign lane = address[LANE_BITS-1:0];

  // Lanes below the start lane hold the bytes that spill into the next row
  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      kofs[b]       = LANE_BITS'(b) - lane;
      bank_row[b]   = (LANE_BITS'(b) < lane) ? base + ROW_BITS'(1) : base;
      bank_we[b]    = store && ({1'b0, kofs[b]} < nbytes);
      bank_wdata[b] = BYTE_BITS'(store_data >> {kofs[b], 3'b000});
    end
  end

  assign ctrl.load  = load;
  assign ctrl.sext  = sext;
  assign ctrl.width = width;
  assign ctrl.lane  = lane;
  assign ctrl.tag   = dest_tag;

endmodule

/* rtl/core/bmlsu_align.sv */
// Response stage: rotate the lane bytes into place, extend and present the result.
module bmlsu_align (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              accept,
  input  bmlsu_pkg::rsp_ctrl_t                              ctrl,
  input  logic [bmlsu_pkg::LANES-1:0][bmlsu_pkg::BYTE_BITS-1:0] bank_rdata,
  output logic                                              done,
  output logic [bmlsu_pkg::WORD_BITS-1:0]                   value,
  output logic [bmlsu_pkg::TAG_BITS-1:0]                    tag,
  output logic                                              value_valid
);
  import bmlsu_pkg::*;

  rsp_ctrl_t              ctrl_q;
  logic [WORD_BITS-1:0]   rot;
  logic [WORD_BITS-1:0]   ext;

  // Raise the result strobe in the cycle after the request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  // Hold the request control alongside the memory read
  always_ff @(posedge clk) begin
    if (accept) begin
      ctrl_q <= ctrl;
    end
  end

  // Bring the start lane down to byte 0, wrapping across lanes
  assign rot = WORD_BITS'({bank_rdata, bank_rdata} >> {ctrl_q.lane, 3'b000});

  // Extend per access size
  always_comb begin
    case (ctrl_q.width)
      W_BYTE:  ext = {{(WORD_BITS-8){ctrl_q.sext & rot[7]}}, rot[7:0]};
      W_HALF:  ext = {{(WORD_BITS-16){ctrl_q.sext & rot[15]}}, rot[15:0]};
      W_WORD:  ext = rot;
      default: ext = rot;
    endcase
  end

  // Drop value and tag for stores and unknown operations
  assign value_valid = done & ctrl_q.load;
  assign value       = value_valid ? ext : '0;
  assign tag         = value_valid ? ctrl_q.tag : '0;

endmodule

/* rtl/core/byte_memory_load_store_unit.sv */
// Byte memory load/store unit: four byte-lane RAMs, address stage and response stage.
// The result strobe done rises in the cycle after the request is taken.
// Throughput: one request per cycle while busy is low, set by the single-port RAMs.
// Every request, store or unknown op included, gives exactly one result.
// Reset holds busy high through reset and in the cycle after; memory is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module byte_memory_load_store_unit #(
  parameter int ADDR_BITS = bmlsu_pkg::DEFAULT_ADDR_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [bmlsu_pkg::OP_BITS-1:0]   op,
  input  logic [ADDR_BITS-1:0]            address,
  input  logic [bmlsu_pkg::WORD_BITS-1:0] store_data,
  input  logic [bmlsu_pkg::TAG_BITS-1:0]  dest_tag,
  output logic                            done,
  output logic [bmlsu_pkg::WORD_BITS-1:0] value,
  output logic [bmlsu_pkg::TAG_BITS-1:0]  tag,
  output logic                            value_valid
);
  import bmlsu_pkg::*;

  localparam int ROW_BITS = ADDR_BITS - LANE_BITS;

  logic                                 accept;
  logic [LANES-1:0][ROW_BITS-1:0]       bank_row;
  logic [LANES-1:0]                     bank_we;
  logic [LANES-1:0][BYTE_BITS-1:0]      bank_wdata;
  logic [LANES-1:0][BYTE_BITS-1:0]      bank_rdata;
  rsp_ctrl_t                            ctrl;

  // Hold busy through reset, then take a request every cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign accept = start && !busy && !rst;

  bmlsu_route #(
    .ADDR_BITS(ADDR_BITS)
  ) u_route (
    .op        (op),
    .address   (address),
    .store_data(store_data),
    .dest_tag  (dest_tag),
    .bank_row  (bank_row),
    .bank_we   (bank_we),
    .bank_wdata(bank_wdata),
    .ctrl      (ctrl)
  );

  // One RAM per byte lane
  for (genvar b = 0; b < LANES; b++) begin : g_bank
    bmlsu_bank #(
      .ROW_BITS(ROW_BITS)
    ) u_bank (
      .clk  (clk),
      .en   (accept),
      .we   (bank_we[b]),
      .row  (bank_row[b]),
      .wdata(bank_wdata[b]),
      .rdata(bank_rdata[b])
    );
  end

  bmlsu_align u_align (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .ctrl       (ctrl),
    .bank_rdata (bank_rdata),
    .done       (done),
    .value      (value),
    .tag        (tag),
    .value_valid(value_valid)
  );

  // Every result follows a request taken in the cycle before
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("result strobe without a request one cycle before");

  a_request_answered: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("request without a result");

  // A store word writes all four lanes
  a_sw_all_lanes: assert property (@(posedge clk) disable iff (rst)
    (accept && op_t'(op) == OP_SW) |-> $countones(bank_we) == LANES)
    else $error("word store does not write every lane");

  // A result without a loaded value carries zero value and tag
  a_store_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !value_valid) |-> (value == '0 && tag == '0))
    else $error("non-load result carries data");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the byte memory load/store unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmlsu_pkg::*;

  localparam int ADDR_W      = DEFAULT_ADDR_BITS;
  localparam int MEM_BYTES   = 1 << ADDR_W;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 20;

  // Op codes outside the defined set
  localparam logic [OP_BITS-1:0] OP_UNKNOWN_LO = 4'd9;
  localparam logic [OP_BITS-1:0] OP_UNKNOWN_HI = 4'd15;

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic [TAG_BITS-1:0]  tag;
    logic                 valid;
  } mem_rsp_t;

  logic                 clk        = 1'b0;
  logic                 rst        = 1'b1;
  logic                 start      = 1'b0;
  logic [OP_BITS-1:0]   op         = '0;
  logic [ADDR_W-1:0]    address    = '0;
  logic [WORD_BITS-1:0] store_data = '0;
  logic [TAG_BITS-1:0]  dest_tag   = '0;
  logic                 busy;
  logic                 done;
  logic [WORD_BITS-1:0] value;
  logic [TAG_BITS-1:0]  tag;
  logic                 value_valid;

  // Shadow memory and the list of byte addresses written so far
  bit [7:0]          mem_image [MEM_BYTES];
  bit                written [MEM_BYTES];
  bit [ADDR_W-1:0]   written_addrs [$];
  mem_rsp_t          expected_rsp [$];

  bit gaps_on = 1'b1;
  int err_cnt = 0;
  int cycles = 0;
  int items_sent = 0;
  int n_load = 0;
  int n_store = 0;
  int n_other = 0;
  int n_checked = 0;

  always #10 clk = ~clk;

  byte_memory_load_store_unit #(
    .ADDR_BITS(ADDR_W)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .address    (address),
    .store_data (store_data),
    .dest_tag   (dest_tag),
    .done       (done),
    .value      (value),
    .tag        (tag),
    .value_valid(value_valid)
  );

  // Number of bytes an op touches
  function automatic int span(input logic [OP_BITS-1:0] code);
    case (code)
      OP_LB, OP_LBU, OP_SB:  return 1;
      OP_LH, OP_LHU, OP_SH:  return 2;
      OP_FETCH, OP_LW, OP_SW: return 4;
      default:               return 0;
    endcase
  endfunction

  // True when every byte a load would read has been written
  function automatic bit readable(input logic [OP_BITS-1:0] code,
                                  input logic [ADDR_W-1:0] addr);
    int n;
    n = span(code);
    for (int k = 0; k < n; k++) begin
      if (!written[ADDR_W'(addr + k)]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Apply one request to the shadow memory and return the response it gives
  function automatic mem_rsp_t access_mem(input logic [OP_BITS-1:0]   code,
                                          input logic [ADDR_W-1:0]    addr,
                                          input logic [WORD_BITS-1:0] data,
                                          input logic [TAG_BITS-1:0]  dtag);
    mem_rsp_t             rsp;
    logic [WORD_BITS-1:0] word;
    logic [ADDR_W-1:0]    idx;
    int                   n;
    rsp = '0;
    word = '0;
    n = span(code);
    case (code)
      OP_SB, OP_SH, OP_SW: begin
        for (int k = 0; k < n; k++) begin
          idx = ADDR_W'(addr + k);
          mem_image[idx] = data[8*k +: 8];
          if (!written[idx]) begin
            written[idx] = 1'b1;
            written_addrs.push_back(idx);
          end
        end
        n_store++;
      end
      OP_FETCH, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
        for (int k = 0; k < n; k++) word[8*k +: 8] = mem_image[ADDR_W'(addr + k)];
        // Sign-extend the signed narrow loads
        if (code == OP_LB) word = {{24{word[7]}}, word[7:0]};
        if (code == OP_LH) word = {{16{word[15]}}, word[15:0]};
        rsp.value = word;
        rsp.tag   = dtag;
        rsp.valid = 1'b1;
        n_load++;
      end
      default: n_other++;
    endcase
    return rsp;
  endfunction

  // Drive one request, wait until it is taken and record its response
  task automatic send_req(input logic [OP_BITS-1:0]   code,
                          input logic [ADDR_W-1:0]    addr,
                          input logic [WORD_BITS-1:0] data,
                          input logic [TAG_BITS-1:0]  dtag);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    op         <= code;
    address    <= addr;
    store_data <= data;
    dest_tag   <= dtag;
    // Busy is stable at the falling edge; the request is taken at the next rising edge
    @(negedge clk);
    while (busy !== 1'b0) begin
      @(posedge clk);
      @(negedge clk);
    end
    expected_rsp.push_back(access_mem(code, addr, data, dtag));
    items_sent++;
    @(posedge clk);
  endtask

  // Pick a load and an address whose bytes are all written
  task automatic choose_load(output logic [OP_BITS-1:0] code,
                             output logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] b;
    code = 4'($urandom_range(OP_FETCH, OP_LHU));
    for (int tries = 0; tries < 8; tries++) begin
      b = written_addrs[$urandom_range(0, written_addrs.size() - 1)];
      addr = ADDR_W'(b - $urandom_range(0, span(code) - 1));
      if (readable(code, addr)) return;
    end
    code = OP_LBU;
    addr = b;
  endtask

  // Address near the top or bottom of memory (wrapping past address 0) or anywhere
  function automatic logic [ADDR_W-1:0] store_addr();
    if ($urandom_range(0, 1)) return ADDR_W'($urandom_range(0, 31) - 16);
    return ADDR_W'($urandom);
  endfunction

  task automatic test_directed();
    // Known pattern at address 0: positive and negative bytes and halves
    send_req(OP_SW, 16'h0000, 32'h80FF_7F01, 5'd0);
    send_req(OP_LW, 16'h0000, 32'h0000_0000, 5'd31);
    send_req(OP_FETCH, 16'h0000, $urandom, 5'd17);
    send_req(OP_LB, 16'h0000, $urandom, 5'd1);
    send_req(OP_LB, 16'h0001, $urandom, 5'd2);
    send_req(OP_LB, 16'h0002, $urandom, 5'd3);
    send_req(OP_LB, 16'h0003, $urandom, 5'd4);
    send_req(OP_LBU, 16'h0002, $urandom, 5'd5);
    send_req(OP_LBU, 16'h0003, $urandom, 5'd6);
    send_req(OP_LH, 16'h0000, $urandom, 5'd7);
    send_req(OP_LH, 16'h0002, $urandom, 5'd8);
    send_req(OP_LHU, 16'h0002, $urandom, 5'd9);
    send_req(OP_LH, 16'h0001, $urandom, 5'd10);
    // Word that wraps past the top address into addresses 0 and 1
    send_req(OP_SW, 16'hFFFE, 32'hA5C3_5A3C, 5'd11);
    send_req(OP_LW, 16'hFFFE, $urandom, 5'd12);
    send_req(OP_LH, 16'hFFFF, $urandom, 5'd13);
    send_req(OP_FETCH, 16'hFFFF, $urandom, 5'd14);
    // Half store writes only its two low bytes
    send_req(OP_SH, 16'h8000, 32'h1234_ABCD, 5'd15);
    send_req(OP_LHU, 16'h8000, $urandom, 5'd16);
    send_req(OP_LH, 16'h8000, $urandom, 5'd18);
    // Top byte with all ones
    send_req(OP_SB, 16'hFFFF, 32'hFFFF_FFFF, 5'd19);
    send_req(OP_LB, 16'hFFFF, $urandom, 5'd31);
    // Undefined ops leave memory alone and return nothing valid
    send_req(OP_UNKNOWN_LO, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
    send_req(OP_UNKNOWN_HI, 16'h0000, 32'hFFFF_FFFF, 5'd31);
    send_req(OP_LW, 16'h0000, $urandom, 5'd20);
  endtask

  // Mixed stores, loads, store-then-load pairs and some undefined ops
  task automatic test_random_traffic(input int n_items);
    logic [OP_BITS-1:0] code;
    logic [ADDR_W-1:0]  addr;
    int                 pick;
    int                 target;
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        send_req(4'($urandom_range(OP_SB, OP_SW)), store_addr(), $urandom,
                 5'($urandom));
      end else if (pick < 35) begin
        send_req(4'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI)), ADDR_W'($urandom),
                 $urandom, 5'($urandom));
      end else if (pick < 55) begin
        // Read right behind the write to the same address
        addr = store_addr();
        send_req(4'($urandom_range(OP_SB, OP_SW)), addr, $urandom, 5'($urandom));
        code = 4'($urandom_range(OP_FETCH, OP_LHU));
        if (!readable(code, addr)) code = OP_LBU;
        send_req(code, addr, $urandom, 5'($urandom));
      end else begin
        choose_load(code, addr);
        send_req(code, addr, $urandom, 5'($urandom));
      end
    end
  endtask

  task automatic test_back_to_back(input int n_items);
    gaps_on = 1'b0;
    test_random_traffic(n_items);
    gaps_on = 1'b1;
  endtask

  // Check each response against the oldest expected one
  always @(negedge clk) begin
    mem_rsp_t exp_rsp;
    if (!rst && done === 1'b1) begin
      if (expected_rsp.size() == 0) begin
        err_cnt++;
        if (err_cnt <= REPORT_MAX)
          $display("%0t: response with none expected: value %h tag %h valid %b",
                   $time, value, tag, value_valid);
      end else begin
        exp_rsp = expected_rsp.pop_front();
        n_checked++;
        if (value !== exp_rsp.value || tag !== exp_rsp.tag ||
            value_valid !== exp_rsp.valid) begin
          err_cnt++;
          if (err_cnt <= REPORT_MAX)
            $display("%0t: mismatch expected value %h tag %h valid %b, actual %h %h %b",
                     $time, exp_rsp.value, exp_rsp.tag, exp_rsp.valid,
                     value, tag, value_valid);
        end
      end
    end else if (!rst && done !== 1'b0) begin
      err_cnt++;
      if (err_cnt <= REPORT_MAX) $display("%0t: done strobe unknown: %b", $time, done);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d responses pending",
               cycles, expected_rsp.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_traffic(600);
    test_back_to_back(100);
    start <= 1'b0;
    // Drain the response pipe
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("Sent %0d requests: %0d loads or fetches, %0d stores, %0d undefined ops",
             items_sent, n_load, n_store, n_other);
    $display("Checked %0d responses, %0d errors", n_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bmlsu_pkg.sv
rtl/core/bmlsu_bank.sv
rtl/core/bmlsu_route.sv
rtl/core/bmlsu_align.sv
rtl/core/byte_memory_load_store_unit.sv
tb/tb_top.sv
